/* rtl/core/sctt_pkg.sv */
// Shared widths, codes, reset values and types of the soft compare tick timer.
package sctt_pkg;

	localparam int CNT_W_DEF = 32;
	localparam int COUNT_W   = 32;
	localparam int SEC_W     = 32;
	localparam int USEC_W    = 20;
	localparam int TICKS_W   = 32;
	localparam int REQ_W     = 2;
	localparam int PERIOD_W  = 32;
	localparam int RATE_W    = 12;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [REQ_W-1:0] REQ_POLL  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_START = 2'd2;

	localparam logic [1:0] REG_TICK_PERIOD = 2'd0;
	localparam logic [1:0] REG_CYCLES_USEC = 2'd1;
	localparam logic [1:0] REG_ENABLE      = 2'd2;

	localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 32'd500000;
	localparam logic [RATE_W-1:0]   CYCLES_USEC_RST = 12'd50;

	localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
	localparam logic [USEC_W-1:0] USEC_LAST    = 20'd999999;

	typedef struct packed {
		logic [PERIOD_W-1:0] tick_period;
		logic [RATE_W-1:0]   cycles_per_usec;
		logic                enable;
	} cfg_t;

endpackage

/* rtl/core/sctt_if.sv */
// Request and response channel interfaces of the soft compare tick timer.
interface sctt_req_if import sctt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [COUNT_W-1:0] count_now;
	logic [SEC_W-1:0]   base_sec;
	logic [USEC_W-1:0]  base_usec;

	modport source (output valid, req_type, count_now, base_sec, base_usec, input ready);
	modport sink (input valid, req_type, count_now, base_sec, base_usec, output ready);
endinterface

interface sctt_rsp_if import sctt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TICKS_W-1:0] ticks_elapsed;
	logic [SEC_W-1:0]   time_sec;
	logic [USEC_W-1:0]  time_usec;
	logic               count_behind;

	modport source (output valid, ticks_elapsed, time_sec, time_usec, count_behind,
		input ready);
	modport sink (input valid, ticks_elapsed, time_sec, time_usec, count_behind,
		output ready);
endinterface

/* rtl/core/sctt_regs.sv */
// APB configuration registers of the soft compare tick timer.
module sctt_regs import sctt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period     <= TICK_PERIOD_RST;
			cfg_q.cycles_per_usec <= CYCLES_USEC_RST;
			cfg_q.enable          <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_TICK_PERIOD: begin
					cfg_q.tick_period <= pwdata[PERIOD_W-1:0];
				end
				REG_CYCLES_USEC: begin
					cfg_q.cycles_per_usec <= pwdata[RATE_W-1:0];
				end
				REG_ENABLE: begin
					cfg_q.enable <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TICK_PERIOD: prdata = cfg_q.tick_period;
			REG_CYCLES_USEC: prdata = APB_DATA_W'(cfg_q.cycles_per_usec);
			REG_ENABLE:      prdata = APB_DATA_W'(cfg_q.enable);
			default:         prdata = '0;
		endcase
	end

endmodule

/* rtl/core/sctt_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
module sctt_div import sctt_pkg::*; #(
	parameter int DW = CNT_W_DEF,
	parameter int VW = PERIOD_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DW-1:0]    dvd_q;
	logic [VW-1:0]    rem_q;
	logic [VW:0]      trial;
	logic [VW:0]      diff;
	logic             fits;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DW-2:0], fits};
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

/* rtl/core/soft_compare_tick_timer.sv */
// Soft compare tick timer: top level with sequencer, state and response register.
// The divider works on DW = max(COUNTER_WIDTH, 21) bits. One request is worked on at
// a time, and the next is taken as soon as the previous response sits in the output
// register.
// Reset clears the compare value and the last query time and returns the
// configuration to its reset values.
module soft_compare_tick_timer import sctt_pkg::*; #(
	parameter int COUNTER_WIDTH = CNT_W_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sctt_req_if.sink              req,
	sctt_rsp_if.source            rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CW = COUNTER_WIDTH;
	localparam int DW = (CW > 21) ? CW : 21;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_START = 5'd1;
	localparam logic [4:0] S_P_SUB = 5'd2;
	localparam logic [4:0] S_P_CHK = 5'd3;
	localparam logic [4:0] S_P_DIV = 5'd4;
	localparam logic [4:0] S_P_CMP1 = 5'd5;
	localparam logic [4:0] S_P_CMP2 = 5'd6;
	localparam logic [4:0] S_Q_SUB1 = 5'd7;
	localparam logic [4:0] S_Q_SUB2 = 5'd8;
	localparam logic [4:0] S_Q_CHK = 5'd9;
	localparam logic [4:0] S_Q_DIV1 = 5'd10;
	localparam logic [4:0] S_Q_ADD = 5'd11;
	localparam logic [4:0] S_Q_NRM = 5'd12;
	localparam logic [4:0] S_Q_DIV2 = 5'd13;
	localparam logic [4:0] S_Q_SEC = 5'd14;
	localparam logic [4:0] S_Q_FIX = 5'd15;
	localparam logic [4:0] S_Q_INC = 5'd16;
	localparam logic [4:0] S_OUT   = 5'd17;

	cfg_t cfg;

	logic [4:0]         state_q;
	logic [CW-1:0]      cmp_q;
	logic [SEC_W-1:0]   last_sec_q;
	logic [USEC_W-1:0]  last_usec_q;
	logic               rsp_valid_q;

	logic [REQ_W-1:0]   type_q;
	logic [CW-1:0]      cnt_q;
	logic [SEC_W-1:0]   base_sec_q;
	logic [USEC_W-1:0]  base_usec_q;
	logic [CW-1:0]      d_q;
	logic [DW-1:0]      sum_q;
	logic [TICKS_W-1:0] ticks_q;
	logic [SEC_W-1:0]   sec_q;
	logic [USEC_W-1:0]  usec_q;
	logic               behind_q;

	logic [TICKS_W-1:0] rsp_ticks_q;
	logic [SEC_W-1:0]   rsp_sec_q;
	logic [USEC_W-1:0]  rsp_usec_q;
	logic               rsp_behind_q;

	logic [PERIOD_W-1:0] per_eff;
	logic [CW-1:0]       per_cw;
	logic [RATE_W-1:0]   rate_eff;
	logic                req_acc;
	logic                out_load;
	logic                poll_hit;
	logic                same_sec_late;
	logic [DW:0]         ticks_wide;

	logic                div_start;
	logic [DW-1:0]       div_dividend;
	logic [PERIOD_W-1:0] div_divisor;
	logic                div_done;
	logic [DW-1:0]       div_quot;
	logic [PERIOD_W-1:0] div_rem;

	sctt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sctt_div #(
		.DW (DW),
		.VW (PERIOD_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// A zero period or rate behaves as one.
	assign per_eff  = (cfg.tick_period == '0) ? PERIOD_W'(1) : cfg.tick_period;
	assign per_cw   = CW'(per_eff);
	assign rate_eff = (cfg.cycles_per_usec == '0) ? RATE_W'(1) : cfg.cycles_per_usec;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_load  = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);

	// The count must lie strictly ahead of the compare value, within half the counter range.
	assign poll_hit = cfg.enable && (d_q != '0) && !d_q[CW-1];
	assign same_sec_late = (sec_q == last_sec_q) && (usec_q <= last_usec_q);
	assign ticks_wide = (DW + 1)'(div_quot) + 1'b1;

	assign div_start = ((state_q == S_P_CHK) && poll_hit) ||
		((state_q == S_Q_CHK) && !d_q[CW-1]) || (state_q == S_Q_NRM);
	assign div_dividend = (state_q == S_Q_NRM) ? sum_q : DW'(d_q);

	// The divider reads its divisor on every step, so it is held for the whole division.
	always_comb begin
		if (state_q == S_Q_CHK || state_q == S_Q_DIV1) begin
			div_divisor = PERIOD_W'(rate_eff);
		end else if (state_q == S_Q_NRM || state_q == S_Q_DIV2) begin
			div_divisor = PERIOD_W'(USEC_PER_SEC);
		end else begin
			div_divisor = per_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmp_q       <= '0;
			last_sec_q  <= '0;
			last_usec_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						unique case (req.req_type)
							REQ_POLL:  state_q <= S_P_SUB;
							REQ_QUERY: state_q <= S_Q_SUB1;
							REQ_START: state_q <= S_START;
							default:   state_q <= S_OUT;
						endcase
					end
				end
				S_START: begin
					cmp_q   <= cnt_q + per_cw;
					state_q <= S_OUT;
				end
				S_P_SUB: state_q <= S_P_CHK;
				S_P_CHK: state_q <= poll_hit ? S_P_DIV : S_OUT;
				S_P_DIV: begin
					if (div_done) begin
						state_q <= S_P_CMP1;
					end
				end
				// Compare plus ticks times period equals count minus remainder plus period.
				S_P_CMP1: begin
					cmp_q   <= cnt_q - CW'(div_rem);
					state_q <= S_P_CMP2;
				end
				S_P_CMP2: begin
					cmp_q   <= cmp_q + per_cw;
					state_q <= S_OUT;
				end
				S_Q_SUB1: state_q <= S_Q_SUB2;
				S_Q_SUB2: state_q <= S_Q_CHK;
				S_Q_CHK:  state_q <= d_q[CW-1] ? S_Q_ADD : S_Q_DIV1;
				S_Q_DIV1: begin
					if (div_done) begin
						state_q <= S_Q_ADD;
					end
				end
				S_Q_ADD: state_q <= S_Q_NRM;
				S_Q_NRM: state_q <= S_Q_DIV2;
				S_Q_DIV2: begin
					if (div_done) begin
						state_q <= S_Q_SEC;
					end
				end
				S_Q_SEC: state_q <= S_Q_FIX;
				// A time not past the previous one within the same second moves one
				// microsecond beyond it.
				S_Q_FIX: begin
					if (same_sec_late && (last_usec_q == USEC_LAST)) begin
						state_q <= S_Q_INC;
					end else begin
						last_sec_q  <= sec_q;
						last_usec_q <= same_sec_late ? last_usec_q + 1'b1 : usec_q;
						state_q     <= S_OUT;
					end
				end
				S_Q_INC: begin
					last_sec_q  <= sec_q + 1'b1;
					last_usec_q <= '0;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_ticks_q  <= ticks_q;
			rsp_sec_q    <= sec_q;
			rsp_usec_q   <= usec_q;
			rsp_behind_q <= behind_q;
		end
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					type_q      <= req.req_type;
					cnt_q       <= CW'(req.count_now);
					base_sec_q  <= req.base_sec;
					base_usec_q <= req.base_usec;
					ticks_q     <= '0;
					sec_q       <= '0;
					usec_q      <= '0;
					behind_q    <= 1'b0;
				end
			end
			S_P_SUB: d_q <= cnt_q - cmp_q;
			S_P_CMP1: begin
				ticks_q <= (ticks_wide > (DW + 1)'(32'hFFFF_FFFF)) ?
					'1 : TICKS_W'(ticks_wide);
			end
			S_Q_SUB1: d_q <= cnt_q - cmp_q;
			// Cycles since the last tick: count minus (compare minus period).
			S_Q_SUB2: d_q <= d_q + per_cw;
			S_Q_CHK:  behind_q <= d_q[CW-1];
			S_Q_ADD:  sum_q <= DW'(base_usec_q) + (behind_q ? '0 : div_quot);
			S_Q_SEC: begin
				sec_q  <= base_sec_q + SEC_W'(div_quot);
				usec_q <= div_rem[USEC_W-1:0];
			end
			S_Q_FIX: begin
				if (same_sec_late) begin
					usec_q <= (last_usec_q == USEC_LAST) ? '0 : last_usec_q + 1'b1;
				end
			end
			S_Q_INC: sec_q <= sec_q + 1'b1;
			default: begin
			end
		endcase
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.ticks_elapsed = rsp_ticks_q;
	assign rsp.time_sec      = rsp_sec_q;
	assign rsp.time_usec     = rsp_usec_q;
	assign rsp.count_behind  = rsp_behind_q;

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_P_DIV || state_q == S_Q_DIV1 || state_q == S_Q_DIV2))
		else $error("divider finished outside a wait state");

	a_last_time_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && type_q == REQ_QUERY) |->
			(last_sec_q == sec_q && last_usec_q == usec_q))
		else $error("last query time differs from the reported time");

	a_usec_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_usec_q < USEC_PER_SEC))
		else $error("reported microseconds not normalised");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q != S_IDLE))
		else $error("accepted transaction not taken up");

endmodule
